>>> design/thc_pkg.sv
// ----------------------------------------------------------------------------
// thc_pkg
// Shared types, constants and helpers for the temperature and humidity
// compensation pipeline.
// ----------------------------------------------------------------------------
package thc_pkg;

  // pipeline depth: stages 0..3 form the fine temperature, 4..10 the rest
  localparam int unsigned NSTG     = 11;
  localparam int unsigned FINE_STG = 4;
  localparam int unsigned HUM_STG  = NSTG - FINE_STG;

  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 24;

  localparam logic [31:0] FINE_OFS   = 32'd76800;
  localparam logic [31:0] RND_P      = 32'd16384;
  localparam logic [31:0] Q_BIAS_1   = 32'd32768;
  localparam logic [31:0] Q_BIAS_2   = 32'd2097152;
  localparam logic [31:0] RND_Q      = 32'd8192;
  localparam logic [31:0] RND_T      = 32'd128;
  localparam logic signed [31:0] HUM_MAX  = 32'sd419430400;
  localparam logic signed [31:0] TEMP_MIN = -32'sd4000;
  localparam logic signed [31:0] TEMP_MAX = 32'sd8500;

  typedef enum logic [CFG_IDX_W-1:0] {
    RI_TEMP_COEF_1  = 3'd0,
    RI_TEMP_COEF_2  = 3'd1,
    RI_TEMP_COEF_3  = 3'd2,
    RI_HUM_COEF_1   = 3'd3,
    RI_HUM_COEF_2   = 3'd4,
    RI_HUM_COEF_3   = 3'd5,
    RI_HUM_COEF_4_5 = 3'd6,
    RI_HUM_COEF_6   = 3'd7
  } reg_idx_t;

  typedef struct packed {
    logic [15:0] t1;
    logic [15:0] t2;
    logic [15:0] t3;
    logic [7:0]  h1;
    logic [15:0] h2;
    logic [7:0]  h3;
    logic [23:0] h45;
    logic [7:0]  h6;
  } coef_t;

  // arithmetic right shift of a 32-bit two's complement pattern
  function automatic logic [31:0] asr32(input logic [31:0] x, input int unsigned sh);
    asr32 = 32'($signed(x) >>> sh);
  endfunction

endpackage

>>> design/thc_ctrl.sv
// ----------------------------------------------------------------------------
// thc_ctrl
// Valid bits and per-stage load enables for the compensation pipeline.
// A stage loads when it is empty or when the stage after it loads.
// ----------------------------------------------------------------------------
module thc_ctrl (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_ready,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic [thc_pkg::NSTG-1:0] stg_en
);
  import thc_pkg::*;

  logic [NSTG-1:0] vld_r;
  logic [NSTG-1:0] vld_nxt;

  // collapse bubbles: an empty stage always takes the beat in front of it
  always_comb begin
    stg_en[NSTG-1] = ~vld_r[NSTG-1] | out_ready;
    for (int k = NSTG - 2; k >= 0; k--) begin
      stg_en[k] = ~vld_r[k] | stg_en[k+1];
    end
  end

  always_comb begin
    vld_nxt = vld_r;
    if (stg_en[0]) vld_nxt[0] = in_valid;
    for (int k = 1; k < NSTG; k++) begin
      if (stg_en[k]) vld_nxt[k] = vld_r[k-1];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  assign in_ready  = stg_en[0];
  assign out_valid = vld_r[NSTG-1];

endmodule

>>> design/thc_fine.sv
// ----------------------------------------------------------------------------
// thc_fine
// Stages 0..3: fine temperature value from the raw temperature reading.
// The raw humidity reading rides along.
// ----------------------------------------------------------------------------
module thc_fine (
  input  logic                         clk,
  input  logic [thc_pkg::FINE_STG-1:0] stg_en,
  input  thc_pkg::coef_t               coef,
  input  logic [19:0]                  raw_temp,
  input  logic [15:0]                  raw_hum,
  output logic [31:0]                  fine,
  output logic [15:0]                  hum
);
  import thc_pkg::*;

  logic [31:0] t1_w;
  logic [31:0] t2_w;
  logic [31:0] t3_w;

  logic [31:0] a_r, b_r;
  logic [31:0] m1_r, bb_r;
  logic [31:0] var1_r, m2_r;
  logic [31:0] fine_r;
  logic [15:0] hum0_r, hum1_r, hum2_r, hum3_r;

  assign t1_w = {16'd0, coef.t1};
  assign t2_w = {{16{coef.t2[15]}}, coef.t2};
  assign t3_w = {{16{coef.t3[15]}}, coef.t3};

  always_ff @(posedge clk) begin
    if (stg_en[0]) begin
      a_r    <= {15'd0, raw_temp[19:3]} - {t1_w[30:0], 1'b0};
      b_r    <= {16'd0, raw_temp[19:4]} - t1_w;
      hum0_r <= raw_hum;
    end
    if (stg_en[1]) begin
      m1_r   <= a_r * t2_w;
      bb_r   <= b_r * b_r;
      hum1_r <= hum0_r;
    end
    if (stg_en[2]) begin
      var1_r <= asr32(m1_r, 11);
      m2_r   <= asr32(bb_r, 12) * t3_w;
      hum2_r <= hum1_r;
    end
    if (stg_en[3]) begin
      fine_r <= var1_r + asr32(m2_r, 14);
      hum3_r <= hum2_r;
    end
  end

  assign fine = fine_r;
  assign hum  = hum3_r;

endmodule

>>> design/thc_hum.sv
// ----------------------------------------------------------------------------
// thc_hum
// Stages 4..10: saturated temperature and the humidity formula with its
// clamp, at most one multiplier rank per stage.
// ----------------------------------------------------------------------------
module thc_hum (
  input  logic                        clk,
  input  logic [thc_pkg::HUM_STG-1:0] stg_en,
  input  thc_pkg::coef_t              coef,
  input  logic [31:0]                 fine,
  input  logic [15:0]                 hum,
  output logic signed [14:0]          temp_centi,
  output logic [16:0]                 hum_q10
);
  import thc_pkg::*;

  logic [31:0] h1_w, h2_w, h3_w, h5_w, h6_w;
  logic [31:0] v_w, t5_w, tcw_w, pin_w, hv_w;
  logic signed [14:0] tc_nxt;
  logic [16:0] hq_nxt;

  logic signed [14:0] tc_r [HUM_STG];
  logic [31:0] mh5_r, mv6_r, mv3_r;
  logic [15:0] hum4_r;
  logic [31:0] p5_r, m3_r;
  logic [31:0] p6_r, m4_r;
  logic [31:0] v7_r, v8_r, v9_r;
  logic [31:0] sqsq_r, m6_r;
  logic [16:0] hq_r;

  assign h1_w = {24'd0, coef.h1};
  assign h2_w = {{16{coef.h2[15]}}, coef.h2};
  assign h3_w = {24'd0, coef.h3};
  assign h5_w = {{20{coef.h45[11]}}, coef.h45[11:0]};
  assign h6_w = {{24{coef.h6[7]}}, coef.h6};

  // stage 4 logic
  assign v_w   = fine - FINE_OFS;
  assign t5_w  = {fine[29:0], 2'b00} + fine + RND_T;
  assign tcw_w = asr32(t5_w, 8);

  always_comb begin
    if ($signed(tcw_w) < TEMP_MIN) begin
      tc_nxt = 15'(TEMP_MIN);
    end else if ($signed(tcw_w) > TEMP_MAX) begin
      tc_nxt = 15'(TEMP_MAX);
    end else begin
      tc_nxt = tcw_w[14:0];
    end
  end

  // stage 5 logic: coefficient four is bits 23:12 of h45, and all 12 of its bits survive the shift
  assign pin_w = {2'b00, hum4_r, 14'd0} - {coef.h45[23:12], 20'd0} - mh5_r + RND_P;

  // stage 10 logic: subtract the square term, clamp, drop to Q7.10
  assign hv_w = v9_r - asr32(m6_r, 4);

  always_comb begin
    if ($signed(hv_w) < 0) begin
      hq_nxt = '0;
    end else if ($signed(hv_w) > HUM_MAX) begin
      hq_nxt = HUM_MAX[28:12];
    end else begin
      hq_nxt = hv_w[28:12];
    end
  end

  always_ff @(posedge clk) begin
    if (stg_en[0]) begin
      tc_r[0] <= tc_nxt;
      mh5_r   <= h5_w * v_w;
      mv6_r   <= v_w * h6_w;
      mv3_r   <= v_w * h3_w;
      hum4_r  <= hum;
    end
    if (stg_en[1]) begin
      p5_r <= asr32(pin_w, 15);
      m3_r <= asr32(mv6_r, 10) * (asr32(mv3_r, 11) + Q_BIAS_1);
    end
    if (stg_en[2]) begin
      p6_r <= p5_r;
      m4_r <= (asr32(m3_r, 10) + Q_BIAS_2) * h2_w;
    end
    if (stg_en[3]) begin
      v7_r <= p6_r * asr32(m4_r + RND_Q, 14);
    end
    if (stg_en[4]) begin
      sqsq_r <= asr32(v7_r, 15) * asr32(v7_r, 15);
      v8_r   <= v7_r;
    end
    if (stg_en[5]) begin
      m6_r <= asr32(sqsq_r, 7) * h1_w;
      v9_r <= v8_r;
    end
    if (stg_en[6]) begin
      hq_r <= hq_nxt;
    end
    // carry the temperature result alongside
    for (int k = 1; k < HUM_STG; k++) begin
      if (stg_en[k]) tc_r[k] <= tc_r[k-1];
    end
  end

  assign temp_centi = tc_r[HUM_STG-1];
  assign hum_q10    = hq_r;

endmodule

>>> design/temp_humidity_compensation.sv
// ----------------------------------------------------------------------------
// temp_humidity_compensation
// 32-bit integer temperature and humidity compensation, fully pipelined.
// ----------------------------------------------------------------------------
// Takes one beat of raw temperature (20 bits) and raw humidity (16 bits) and
// returns temperature in 0.01 degC saturated to -4000..8500 and relative
// humidity in Q7.10 percent. The pipeline is 11 register stages deep, with
// at most one 32x32 multiplier rank per stage; a beat enters stage 0 on the
// edge that accepts it and its result is valid once it reaches stage 10.
// One beat can be accepted every cycle unless a stalled output fills the pipeline.
// Empty stages absorb new beats while the output waits. Write the eight
// coefficient registers (index 0..7) only while the pipeline is empty.
// ----------------------------------------------------------------------------
module temp_humidity_compensation (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_we,
  input  logic [thc_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [thc_pkg::CFG_DATA_W-1:0]    cfg_wdata,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [19:0]                       in_raw_temp,
  input  logic [15:0]                       in_raw_hum,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic signed [14:0]                out_temp_centi,
  output logic [16:0]                       out_hum_q10
);
  import thc_pkg::*;

  coef_t           coef_r;
  coef_t           coef_nxt;
  logic [NSTG-1:0] stg_en;
  logic [31:0]     fine;
  logic [15:0]     hum;

  always_comb begin
    coef_nxt = coef_r;
    if (cfg_we) begin
      unique case (reg_idx_t'(cfg_index))
        RI_TEMP_COEF_1:  coef_nxt.t1  = cfg_wdata[15:0];
        RI_TEMP_COEF_2:  coef_nxt.t2  = cfg_wdata[15:0];
        RI_TEMP_COEF_3:  coef_nxt.t3  = cfg_wdata[15:0];
        RI_HUM_COEF_1:   coef_nxt.h1  = cfg_wdata[7:0];
        RI_HUM_COEF_2:   coef_nxt.h2  = cfg_wdata[15:0];
        RI_HUM_COEF_3:   coef_nxt.h3  = cfg_wdata[7:0];
        RI_HUM_COEF_4_5: coef_nxt.h45 = cfg_wdata[23:0];
        RI_HUM_COEF_6:   coef_nxt.h6  = cfg_wdata[7:0];
        default:         coef_nxt     = coef_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      coef_r <= '0;
    end else begin
      coef_r <= coef_nxt;
    end
  end

  thc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .stg_en    (stg_en)
  );

  thc_fine u_fine (
    .clk      (clk),
    .stg_en   (stg_en[FINE_STG-1:0]),
    .coef     (coef_r),
    .raw_temp (in_raw_temp),
    .raw_hum  (in_raw_hum),
    .fine     (fine),
    .hum      (hum)
  );

  thc_hum u_hum (
    .clk        (clk),
    .stg_en     (stg_en[NSTG-1:FINE_STG]),
    .coef       (coef_r),
    .fine       (fine),
    .hum        (hum),
    .temp_centi (out_temp_centi),
    .hum_q10    (out_hum_q10)
  );

endmodule
